FILE: sv/tcdq_pkg.sv
// Package for the two-class deque queue: depth, derived widths, function and
// status codes, the request and response structs and the cell control struct.
// No dependencies.
package tcdq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned HANDLE_W    = 16;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned OCC_OUT_W   = 5;

  localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
  localparam logic [1:0] FUNC_DEQUEUE = 2'd1;
  localparam logic [1:0] FUNC_PEEK    = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_IGNORED = 2'd3;

  typedef struct packed {
    logic [1:0]          func;
    logic [HANDLE_W-1:0] customer_handle;
    logic                is_priority;
    logic [POS_W-1:0]    position;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]  handle_out;
    logic [1:0]           status;
    logic [OCC_OUT_W-1:0] occupancy_out;
    logic                 empty_flag;
  } rsp_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [HANDLE_W-1:0] load_data;
  } cell_ctrl_t;

endpackage

FILE: sv/tcdq_cell.sv
// One entry of the queue chain: holds a handle and loads it from the
// request, from the neighbor nearer the head or from the one nearer the tail.
// Depends on tcdq_pkg.
module tcdq_cell import tcdq_pkg::*; (
  input  logic                clk_i,
  input  cell_ctrl_t          ctrl_i,
  input  logic [HANDLE_W-1:0] prev_i,
  input  logic [HANDLE_W-1:0] next_i,
  output logic [HANDLE_W-1:0] data_o
);

  logic [HANDLE_W-1:0] data_q, data_d;

  always_comb begin
    unique case (ctrl_i.op)
      CELL_HOLD:      data_d = data_q;
      CELL_LOAD:      data_d = ctrl_i.load_data;
      CELL_FROM_PREV: data_d = prev_i;
      CELL_FROM_NEXT: data_d = next_i;
      default:        data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: sv/two_class_deque_queue_core.sv
// Top level of the two-class deque queue: occupancy control, the chain of
// entry cells and the registered result. Depends on tcdq_pkg and tcdq_cell.

// The queue takes one transaction per clock: busy is always low, and the
// result of the transaction accepted at one edge is on rsp_o, marked by
// valid_o, during the following cycle only. The receiver cannot stall, so
// it must take every result in that cycle. Entries sit in a chain of
// QUEUE_DEPTH cells with the head in the first cell; a priority enqueue
// shifts the whole chain one cell toward the tail, and a dequeue shifts it one
// cell toward the head.
module two_class_deque_queue_core import tcdq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic valid_o,
  output rsp_t rsp_o
);

  logic [OCC_W-1:0]    occ_q, occ_d;
  logic                valid_q;
  rsp_t                rsp_q, rsp_d;
  cell_ctrl_t          ctrl [QUEUE_DEPTH];
  logic [HANDLE_W-1:0] cell_data [QUEUE_DEPTH];
  logic                full, empty;
  logic [IDX_W+POS_W-1:0] pos_ext;
  logic [IDX_W+POS_W-1:0] occ_ext;
  logic [OCC_W+OCC_OUT_W-1:0] occ_out_ext;

  assign busy    = 1'b0;
  assign full    = (occ_q == OCC_W'(QUEUE_DEPTH));
  assign empty   = (occ_q == '0);
  assign pos_ext = {{IDX_W{1'b0}}, req_i.position};
  assign occ_ext = (IDX_W + POS_W)'(occ_q);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ctrl[i].op        = CELL_HOLD;
      ctrl[i].load_data = req_i.customer_handle;
    end
    occ_d            = occ_q;
    rsp_d.handle_out = '0;
    rsp_d.status     = STATUS_OK;
    if (start) begin
      unique case (req_i.func)
        FUNC_ENQUEUE: begin
          if (req_i.customer_handle == '0) begin
            rsp_d.status = STATUS_IGNORED;
          end else if (full) begin
            rsp_d.status = STATUS_FULL;
          end else begin
            if (req_i.is_priority && !empty) begin
              // New head enters the first cell; everything moves toward the tail.
              ctrl[0].op = CELL_LOAD;
              for (int i = 1; i < QUEUE_DEPTH; i++) begin
                ctrl[i].op = CELL_FROM_PREV;
              end
            end else begin
              for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (occ_q == OCC_W'(i)) ctrl[i].op = CELL_LOAD;
              end
            end
            occ_d = occ_q + 1'b1;
          end
        end
        FUNC_DEQUEUE: begin
          if (empty) begin
            rsp_d.status = STATUS_EMPTY;
          end else begin
            rsp_d.handle_out = cell_data[0];
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              ctrl[i].op = CELL_FROM_NEXT;
            end
            occ_d = occ_q - 1'b1;
          end
        end
        FUNC_PEEK: begin
          if (pos_ext >= occ_ext) begin
            rsp_d.status = STATUS_EMPTY;
          end else begin
            rsp_d.handle_out = cell_data[pos_ext[IDX_W-1:0]];
          end
        end
        default: rsp_d.status = STATUS_IGNORED;
      endcase
    end
    occ_out_ext         = (OCC_W + OCC_OUT_W)'(occ_d);
    rsp_d.occupancy_out = occ_out_ext[OCC_OUT_W-1:0];
    rsp_d.empty_flag    = (occ_d == '0);
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [HANDLE_W-1:0] prev_data, next_data;
    if (g == 0) begin : g_first
      assign prev_data = req_i.customer_handle;
    end else begin : g_mid
      assign prev_data = cell_data[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_inner
      assign next_data = cell_data[g+1];
    end
    tcdq_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl[g]),
      .prev_i (prev_data),
      .next_i (next_data),
      .data_o (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      occ_q   <= occ_d;
      valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  a_result_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> valid_o) else $error("accepted transaction produced no result");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start |=> !valid_o) else $error("result without an accepted transaction");

  a_occ_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(QUEUE_DEPTH)) else $error("occupancy above queue depth");

  a_empty_flag_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (rsp_o.empty_flag == (occ_q == '0)))
    else $error("empty flag disagrees with occupancy");

  a_dequeue_drops_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && req_i.func == FUNC_DEQUEUE && occ_q != '0)
      |=> occ_q == $past(occ_q) - OCC_W'(1))
    else $error("dequeue did not reduce occupancy by one");

endmodule

FILE: test/tb_two_class_deque_queue_core.sv
// Self-checking testbench for two_class_deque_queue_core: directed corner cases, then
// random enqueue, dequeue and peek traffic checked against a ring predictor.
// Depends on tcdq_pkg and the core RTL.
module tb_two_class_deque_queue_core import tcdq_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned SEGMENT_LEN = 40;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } mix_e;

  typedef struct {
    req_t        req;
    int unsigned idle_pct;
    bit          wait_drain;
  } backlog_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic valid_o;
  rsp_t rsp_o;

  two_class_deque_queue_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  backlog_item_t req_backlog[$];
  rsp_t          predicted_rsp[$];

  // Predictor state: the ring of handles, its head index and its fill count.
  logic [HANDLE_W-1:0] ring_handles[QUEUE_DEPTH];
  int unsigned         ring_head = 0;
  int unsigned         ring_count = 0;

  int unsigned shadow_count = 0;
  int unsigned total_items = 0;
  int unsigned accepted_total = 0;
  int unsigned checked_total = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned outcome_count[4][4];
  bit          took_item = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    error_count++;
  endtask

  function automatic rsp_t deque_step(req_t r);
    rsp_t o;
    int unsigned slot;
    o = '0;
    o.status = STATUS_OK;
    case (r.func)
      FUNC_ENQUEUE: begin
        if (r.customer_handle == '0) begin
          o.status = STATUS_IGNORED;
        end else if (ring_count >= QUEUE_DEPTH) begin
          o.status = STATUS_FULL;
        end else begin
          // A priority handle goes in front of the head unless the ring is empty.
          if (r.is_priority && ring_count != 0) begin
            ring_head = (ring_head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
            slot = ring_head;
          end else begin
            slot = (ring_head + ring_count) % QUEUE_DEPTH;
          end
          ring_handles[slot] = r.customer_handle;
          ring_count++;
        end
      end
      FUNC_DEQUEUE: begin
        if (ring_count == 0) begin
          o.status = STATUS_EMPTY;
        end else begin
          o.handle_out = ring_handles[ring_head];
          ring_head = (ring_head + 1) % QUEUE_DEPTH;
          ring_count--;
        end
      end
      FUNC_PEEK: begin
        if (r.position >= ring_count) begin
          o.status = STATUS_EMPTY;
        end else begin
          o.handle_out = ring_handles[(ring_head + r.position) % QUEUE_DEPTH];
        end
      end
      default: begin
        o.status = STATUS_IGNORED;
      end
    endcase
    o.occupancy_out = OCC_OUT_W'(ring_count);
    o.empty_flag = (ring_count == 0);
    outcome_count[r.func][o.status]++;
    return o;
  endfunction

  // Appends one item to the backlog and tracks the fill level it will leave behind.
  task automatic add_item(logic [1:0] func, logic [HANDLE_W-1:0] handle, logic prio,
                          logic [POS_W-1:0] pos, int unsigned idle_pct, bit wait_drain);
    backlog_item_t it;
    it.req.func = func;
    it.req.customer_handle = handle;
    it.req.is_priority = prio;
    it.req.position = pos;
    it.idle_pct = idle_pct;
    it.wait_drain = wait_drain;
    req_backlog.push_back(it);
    total_items++;
    if (func == FUNC_ENQUEUE && handle != '0 && shadow_count < QUEUE_DEPTH) begin
      shadow_count++;
    end else if (func == FUNC_DEQUEUE && shadow_count != 0) begin
      shadow_count--;
    end
  endtask

  task automatic add_random_item(mix_e mix, int unsigned idle_pct, bit wait_drain);
    int unsigned roll;
    int unsigned enq_pct;
    int unsigned deq_pct;
    logic [1:0] func;
    logic [HANDLE_W-1:0] handle;
    logic [POS_W-1:0] pos;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        enq_pct = 75;
        deq_pct = 10;
      end
      MIX_DRAIN: begin
        enq_pct = 15;
        deq_pct = 70;
      end
      default: begin
        enq_pct = 40;
        deq_pct = 30;
      end
    endcase
    if (roll < enq_pct) begin
      func = FUNC_ENQUEUE;
    end else if (roll < enq_pct + deq_pct) begin
      func = FUNC_DEQUEUE;
    end else if (roll < 97) begin
      func = FUNC_PEEK;
    end else begin
      func = FUNC_UNUSED;
    end
    handle = HANDLE_W'($urandom_range(0, 65535));
    if (func == FUNC_ENQUEUE) begin
      if ($urandom_range(0, 99) < 8) begin
        handle = '0;
      end else if (handle == '0) begin
        handle = '1;
      end
    end
    // Most peeks land on a held entry; the rest may run past the fill level.
    if (shadow_count != 0 && $urandom_range(0, 99) < 75) begin
      pos = POS_W'($urandom_range(0, shadow_count - 1));
    end else begin
      pos = POS_W'($urandom_range(0, 15));
    end
    add_item(func, handle, 1'($urandom_range(0, 1)), pos, idle_pct, wait_drain);
  endtask

  // Acceptance and prediction.
  always @(posedge clk_i) begin
    took_item = rst_ni && start && !busy;
    if (took_item) begin
      predicted_rsp.push_back(deque_step(req_i));
      accepted_total++;
    end
  end

  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && valid_o) begin
      if (predicted_rsp.size() == 0) begin
        report_mismatch($sformatf("result with none expected: handle %h status %0d",
                                  rsp_o.handle_out, rsp_o.status));
      end else begin
        exp_rsp = predicted_rsp.pop_front();
        checked_total++;
        if (rsp_o.handle_out !== exp_rsp.handle_out) begin
          report_mismatch($sformatf("handle_out got %h exp %h",
                                    rsp_o.handle_out, exp_rsp.handle_out));
        end
        if (rsp_o.status !== exp_rsp.status) begin
          report_mismatch($sformatf("status got %0d exp %0d", rsp_o.status, exp_rsp.status));
        end
        if (rsp_o.occupancy_out !== exp_rsp.occupancy_out) begin
          report_mismatch($sformatf("occupancy_out got %0d exp %0d",
                                    rsp_o.occupancy_out, exp_rsp.occupancy_out));
        end
        if (rsp_o.empty_flag !== exp_rsp.empty_flag) begin
          report_mismatch($sformatf("empty_flag got %b exp %b",
                                    rsp_o.empty_flag, exp_rsp.empty_flag));
        end
      end
    end
  end

  // Driver: presents backlog items at the falling edge, with random idle cycles.
  always @(negedge clk_i) begin
    logic drive_start;
    req_t drive_req;
    backlog_item_t nxt;
    drive_start = start;
    drive_req = req_i;
    if (rst_ni) begin
      if (start && took_item) begin
        drive_start = 1'b0;
      end
      if (!drive_start && req_backlog.size() != 0) begin
        nxt = req_backlog[0];
        if (!(nxt.wait_drain && predicted_rsp.size() != 0) &&
            $urandom_range(0, 99) >= nxt.idle_pct) begin
          void'(req_backlog.pop_front());
          drive_start = 1'b1;
          drive_req = nxt.req;
        end
      end
    end
    start <= drive_start;
    req_i <= drive_req;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_two_class_deque_queue_core: errors");
    $finish;
  end

  initial begin
    int unsigned idle_pct;
    int unsigned seg_idle;
    mix_e mix;
    int unsigned ops;
    int unsigned bad;

    // Directed corners: empty queue, null handles, priority ordering, peek limits.
    add_item(FUNC_UNUSED, 16'hFFFF, 1'b1, 4'hF, 33, 1'b0);
    add_item(FUNC_DEQUEUE, 16'h0000, 1'b0, 4'h0, 33, 1'b0);
    add_item(FUNC_PEEK, 16'h0000, 1'b0, 4'h0, 33, 1'b0);
    add_item(FUNC_PEEK, 16'h0000, 1'b0, 4'hF, 33, 1'b0);
    add_item(FUNC_ENQUEUE, 16'h0000, 1'b0, 4'h0, 33, 1'b0);
    add_item(FUNC_ENQUEUE, 16'hFFFF, 1'b1, 4'h0, 33, 1'b0);
    add_item(FUNC_ENQUEUE, 16'h0001, 1'b0, 4'h0, 33, 1'b0);
    add_item(FUNC_ENQUEUE, 16'h8000, 1'b1, 4'h0, 33, 1'b0);
    add_item(FUNC_ENQUEUE, 16'h5555, 1'b1, 4'h0, 33, 1'b0);
    add_item(FUNC_ENQUEUE, 16'hAAAA, 1'b0, 4'h0, 33, 1'b0);
    add_item(FUNC_ENQUEUE, 16'h0000, 1'b1, 4'h0, 33, 1'b0);
    for (int i = 0; i < 6; i++) begin
      add_item(FUNC_PEEK, 16'h0000, 1'b0, POS_W'(i), 33, 1'b0);
    end
    add_item(FUNC_DEQUEUE, 16'h0000, 1'b0, 4'h0, 33, 1'b0);
    add_item(FUNC_UNUSED, 16'h0000, 1'b0, 4'h0, 33, 1'b0);
    for (int i = 0; i < 4; i++) begin
      add_item(FUNC_DEQUEUE, 16'h0000, 1'b0, 4'h0, 33, 1'b0);
    end
    add_item(FUNC_DEQUEUE, 16'hFFFF, 1'b1, 4'hF, 33, 1'b0);

    // Random traffic in three idle phases, in segments that fill, drain or mix.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_pct = (i < RANDOM_ITEMS / 3) ? 33 : (i < 2 * RANDOM_ITEMS / 3) ? 48 : 0;
      if (i % SEGMENT_LEN == 0) begin
        mix = mix_e'($urandom_range(0, 2));
        seg_idle = ($urandom_range(0, 3) == 0) ? 0 : idle_pct;
      end
      if (i % (RANDOM_ITEMS / 3) == 0) begin
        seg_idle = idle_pct;
      end
      add_random_item(mix, seg_idle,
                      (i % (RANDOM_ITEMS / 3) == 0) || ($urandom_range(0, 199) == 0));
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accepted_total < total_items || predicted_rsp.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
    while (predicted_rsp.size() != 0) begin
      void'(predicted_rsp.pop_front());
      report_mismatch("expected result never arrived");
    end

    ops = outcome_count[FUNC_ENQUEUE][STATUS_OK] + outcome_count[FUNC_ENQUEUE][STATUS_FULL]
        + outcome_count[FUNC_ENQUEUE][STATUS_IGNORED];
    $display("Covered %0d transactions, %0d checked; %0d enqueues, %0d full, %0d null.",
             accepted_total, checked_total, ops, outcome_count[FUNC_ENQUEUE][STATUS_FULL],
             outcome_count[FUNC_ENQUEUE][STATUS_IGNORED]);
    bad = outcome_count[FUNC_PEEK][STATUS_EMPTY];
    $display("Dequeues %0d, on empty %0d; peeks %0d, out of range %0d; unused codes %0d.",
             outcome_count[FUNC_DEQUEUE][STATUS_OK], outcome_count[FUNC_DEQUEUE][STATUS_EMPTY],
             outcome_count[FUNC_PEEK][STATUS_OK], bad, outcome_count[FUNC_UNUSED][STATUS_IGNORED]);
    if (error_count == 0) begin
      $display("tb_two_class_deque_queue_core: clean");
    end else begin
      $display("tb_two_class_deque_queue_core: errors");
    end
    $finish;
  end

endmodule
